/* src/ryuv_pkg.sv */
// shared types, constants and helpers for the rgb to yuv 4:2:0 subsampler
package ryuv_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int REG_W        = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int PIX_W        = 8;

  localparam int LINE_WIDTH_RESET   = 640;
  localparam int FRAME_HEIGHT_RESET = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } in_pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_u;
    logic [PIX_W-1:0] chroma_v;
    logic             chroma_valid;
    logic             end_of_line;
    logic             end_of_frame;
  } out_pix_t;

  typedef struct packed {
    logic chroma_valid;
    logic end_of_line;
    logic end_of_frame;
  } pos_flags_t;

  // last counter position for a dimension register, with the value forced into 2..lim
  function automatic int last_index(input logic [REG_W-1:0] v, input int lim);
    int d;
    d = int'(v);
    if (d < 2) begin
      return 1;
    end else if (d > lim) begin
      return lim - 1;
    end
    return d - 1;
  endfunction

endpackage

/* src/ryuv_position.sv */
// raster position tracker: dimension registers, column and row counters, flags
module ryuv_position
  import ryuv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  input  logic                 advance,
  output pos_flags_t           flags
);

  logic [COL_W-1:0] last_col_r;
  logic [ROW_W-1:0] last_row_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             eol, row_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= COL_W'(LINE_WIDTH_RESET - 1);
      last_row_r <= ROW_W'(FRAME_HEIGHT_RESET - 1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LINE_WIDTH:   last_col_r <= COL_W'(last_index(cfg_wdata, MAX_WIDTH));
        REG_FRAME_HEIGHT: last_row_r <= ROW_W'(last_index(cfg_wdata, HEIGHT_LIMIT));
        default:          ;
      endcase
    end
  end

  assign eol      = col_r >= last_col_r;
  assign row_last = row_r >= last_row_r;

  always_comb begin
    col_nxt = col_r + COL_W'(1);
    row_nxt = row_r;
    if (eol) begin
      col_nxt = '0;
      row_nxt = row_last ? '0 : row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign flags.chroma_valid = !col_r[0] && !row_r[0];
  assign flags.end_of_line  = eol;
  assign flags.end_of_frame = eol && row_last;

endmodule

/* src/ryuv_csc.sv */
// color space conversion of one pixel, bt.601 integer coefficients
module ryuv_csc
  import ryuv_pkg::*;
(
  input  in_pix_t    pix,
  input  pos_flags_t flags,
  output out_pix_t   res
);

  logic        [15:0] y_sum;
  logic signed [17:0] r_s, g_s, b_s;
  logic signed [17:0] u_sum, v_sum;

  assign y_sum = 16'(16'd77 * {8'd0, pix.red}) + 16'(16'd150 * {8'd0, pix.green})
               + 16'(16'd29 * {8'd0, pix.blue});

  assign r_s = signed'({10'd0, pix.red});
  assign g_s = signed'({10'd0, pix.green});
  assign b_s = signed'({10'd0, pix.blue});

  // offset of 32768 keeps the shift non-negative and folds in the +128
  assign u_sum = 18'sd32768 - 18'sd43 * r_s - 18'sd84 * g_s + 18'sd127 * b_s;
  assign v_sum = 18'sd32768 + 18'sd127 * r_s - 18'sd106 * g_s - 18'sd21 * b_s;

  always_comb begin
    res.luma         = y_sum[15:8];
    res.chroma_u     = flags.chroma_valid ? u_sum[15:8] : '0;
    res.chroma_v     = flags.chroma_valid ? v_sum[15:8] : '0;
    res.chroma_valid = flags.chroma_valid;
    res.end_of_line  = flags.end_of_line;
    res.end_of_frame = flags.end_of_frame;
  end

endmodule

/* src/rgb_to_yuv420_subsampler_top.sv */
// top level: rgb to yuv 4:2:0 subsampler with input and result registers
// an accepted request passes through the input register and then the result register to the out port
// throughput: one pixel per cycle while out_stall is low, set by the two-register valid/stall pipeline
// a stalled result holds in the result register while one more pixel waits in the input register
// reset: synchronous active low; empties both stages, zeroes the counters,
// and sets the dimensions to 640 by 480
module rgb_to_yuv420_subsampler_top
  import ryuv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_pix_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_pix_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  logic       s1_valid_r;
  in_pix_t    s1_pix_r;
  pos_flags_t s1_flags_r;
  logic       out_valid_r;
  out_pix_t   out_data_r;
  logic       out_ready, s1_ready, accept;
  pos_flags_t flags;
  out_pix_t   res;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign accept    = in_valid && s1_ready;
  assign in_stall  = !s1_ready;

  ryuv_position u_position (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (accept),
    .flags     (flags)
  );

  ryuv_csc u_csc (
    .pix   (s1_pix_r),
    .flags (s1_flags_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= in_data;
      s1_flags_r <= flags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/ryuv_checker.sv */
// port-level checker for the subsampler top level, with its bind
module ryuv_checker
  import ryuv_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_pix_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input side backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // frame end is always a line end
  a_eof_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_of_frame |-> out_data.end_of_line)
    else $error("end of frame without end of line");

  // chroma fields are zero on pixels that carry no chroma
  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.chroma_valid |->
      out_data.chroma_u == '0 && out_data.chroma_v == '0)
    else $error("chroma present on a subsampled pixel");

endmodule

bind rgb_to_yuv420_subsampler_top ryuv_checker u_ryuv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* dv/yuv_stream_checker.sv */
// checker for the rgb to yuv 4:2:0 subsampler: predicts each result and compares it on the out port
module yuv_stream_checker
  import ryuv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_pix_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_pix_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   outstanding
);

  logic [REG_W-1:0] width_reg;
  logic [REG_W-1:0] height_reg;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  out_pix_t         yuv_queue[$];
  out_pix_t         predicted;
  out_pix_t         want;
  int               col_last;
  int               row_last;
  int               err_total = 0;

  assign mismatches = err_total;

  function automatic int usable_dim(input logic [REG_W-1:0] v, input int lim);
    if (v < 2) return 2;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic out_pix_t rgb_to_yuv(input in_pix_t px, input logic chroma_on);
    int r;
    int g;
    int b;
    int u_sum;
    int v_sum;
    out_pix_t o;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    o = '0;
    o.luma = 8'((77 * r + 150 * g + 29 * b) >> 8);
    if (chroma_on) begin
      // offset keeps the floor shift non-negative and folds in the +128
      u_sum = -43 * r - 84 * g + 127 * b + 32768;
      v_sum = 127 * r - 106 * g - 21 * b + 32768;
      o.chroma_u = 8'(u_sum >> 8);
      o.chroma_v = 8'(v_sum >> 8);
      o.chroma_valid = 1'b1;
    end
    return o;
  endfunction

  task automatic check_field(input string field, input int expv, input int actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", field, expv, actv);
      err_total++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg <= REG_W'(LINE_WIDTH_RESET);
      height_reg <= REG_W'(FRAME_HEIGHT_RESET);
      col <= '0;
      row <= '0;
      yuv_queue.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_LINE_WIDTH) begin
          width_reg <= cfg_wdata;
        end else begin
          height_reg <= cfg_wdata;
        end
      end
      if (in_valid && !in_stall) begin
        col_last = usable_dim(width_reg, MAX_WIDTH) - 1;
        row_last = usable_dim(height_reg, HEIGHT_LIMIT) - 1;
        predicted = rgb_to_yuv(in_data, !col[0] && !row[0]);
        predicted.end_of_line = int'(col) >= col_last;
        predicted.end_of_frame = predicted.end_of_line && int'(row) >= row_last;
        if (predicted.end_of_line) begin
          col <= '0;
          row <= (int'(row) >= row_last) ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
        yuv_queue.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (yuv_queue.size() == 0) begin
          $error("result with no request outstanding");
          err_total++;
        end else begin
          want = yuv_queue.pop_front();
          check_field("luma", want.luma, out_data.luma);
          check_field("chroma_u", want.chroma_u, out_data.chroma_u);
          check_field("chroma_v", want.chroma_v, out_data.chroma_v);
          check_field("chroma_valid", want.chroma_valid, out_data.chroma_valid);
          check_field("end_of_line", want.end_of_line, out_data.end_of_line);
          check_field("end_of_frame", want.end_of_frame, out_data.end_of_frame);
        end
      end
      outstanding <= yuv_queue.size();
    end
  end

endmodule

/* dv/rgb_to_yuv420_subsampler_top_test.sv */
// testbench top for the rgb to yuv 4:2:0 subsampler: stimulus, stalls, watchdog and verdict
module rgb_to_yuv420_subsampler_top_test;
  import ryuv_pkg::*;

  localparam int QUIET_LIMIT   = 300;
  localparam int RANDOM_PIXELS = 420;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_pix_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_pix_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LINE_WIDTH;
  logic [REG_W-1:0]     cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  int random_pixels = 0;
  bit calm = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rgb_to_yuv420_subsampler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  yuv_stream_checker yuv_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic logic [PIX_W-1:0] rand_level();
    if ($urandom_range(0, 7) == 0) begin
      return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    end
    return PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic in_pix_t rand_pixel();
    in_pix_t p;
    p.red = rand_level();
    p.green = rand_level();
    p.blue = rand_level();
    return p;
  endfunction

  // mostly small frames so line and frame ends come often
  function automatic logic [REG_W-1:0] rand_dim();
    case ($urandom_range(0, 9))
      0: return REG_W'($urandom_range(0, 1));
      1: return REG_W'(MAX_WIDTH);
      2: return REG_W'($urandom_range(MAX_WIDTH + 1, (1 << REG_W) - 1));
      default: return REG_W'($urandom_range(2, 9));
    endcase
  endfunction

  task automatic send_pixel(input in_pix_t px);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_burst(input int count);
    repeat (count) send_pixel(rand_pixel());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_dims(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h,
                            input bit set_w, input bit set_h);
    if (set_w) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_LINE_WIDTH;
      cfg_wdata <= w;
      @(posedge clk);
    end
    if (set_h) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_FRAME_HEIGHT;
      cfg_wdata <= h;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : result_stall
    int hold;
    wait (rst_n);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    in_pix_t corners[8];
    int count;
    // color extremes, ordered so the chroma extremes fall on even columns
    corners = '{'{8'h00, 8'h00, 8'hFF}, '{8'h00, 8'h00, 8'h00},
                '{8'hFF, 8'hFF, 8'h00}, '{8'hFF, 8'hFF, 8'hFF},
                '{8'hFF, 8'h00, 8'h00}, '{8'h00, 8'hFF, 8'h00},
                '{8'h00, 8'hFF, 8'hFF}, '{8'hFF, 8'h00, 8'hFF}};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (corners[i]) send_pixel(corners[i]);
    drain();
    // dimensions below two, changed mid-line
    write_dims(REG_W'(1), REG_W'(0), 1'b1, 1'b1);
    send_burst(6);
    drain();
    // odd dimensions
    write_dims(REG_W'(3), REG_W'(3), 1'b1, 1'b1);
    send_burst(10);
    drain();
    // oversized width clamps to the maximum, no line end in a short burst
    write_dims(REG_W'((1 << REG_W) - 1), REG_W'(2), 1'b1, 1'b1);
    send_burst(40);
    drain();
    while (random_pixels < RANDOM_PIXELS) begin
      calm = ($urandom_range(0, 3) == 0);
      write_dims(rand_dim(), rand_dim(), $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
      count = $urandom_range(20, 70);
      send_burst(count);
      random_pixels += count;
      drain();
    end
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
